[rtl/core/ffta_pkg.sv]
// Shared types and constants of the first-fit tile range allocator.
`timescale 1ns / 1ps
package ffta_pkg;

  localparam int unsigned MAX_RANGES = 32;
  localparam int unsigned TILE_SPACE = 2048;
  localparam int unsigned IDX_W      = $clog2(MAX_RANGES);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned TILE_W     = 11;
  localparam int unsigned LEN_W      = 12;
  localparam int unsigned CUR_W      = 13;
  localparam int unsigned ENTRY_W    = LEN_W + TILE_W;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RD_ZERO,
    RD_NEXT,
    RD_TAIL,
    RD_PTR_M1,
    RD_PTR_P2
  } rd_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    logic    start;
    logic    scan_step;
    logic    slot_idx;
    logic    slot_held;
    logic    fit_prep;
    logic    ins_step;
    logic    ins_write;
    logic    del_init;
    logic    del_step;
    logic    dec_held;
    logic    set_res;
    status_e res_status;
    logic    load_out;
    rd_sel_e rd_sel;
  } ffta_cmd_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic is_free;
    logic held_zero;
    logic held_full;
    logic count_zero;
    logic scan_hit;
    logic scan_last;
    logic no_fit;
    logic slot_is_held;
    logic ins_last;
    logic del_last;
    logic out_free;
  } ffta_sts_t;

endpackage

[rtl/core/ffta_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ffta_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/ffta_ctrl.sv]
// Controller state machine of the tile range allocator.
`timescale 1ns / 1ps
module ffta_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  ffta_pkg::ffta_sts_t sts_i,
  output ffta_pkg::ffta_cmd_t cmd_o
);
  import ffta_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_START = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_FIT   = 8'b0000_1000,
    S_INS   = 8'b0001_0000,
    S_INSW  = 8'b0010_0000,
    S_DEL   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  assign s_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_status = ST_OK;
    cmd_o.rd_sel     = RD_ZERO;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_START;
        end
      end
      S_START: begin
        cmd_o.start = 1'b1;
        if (!sts_i.is_free) begin
          if (sts_i.held_full) begin
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = ST_FULL;
            state_d          = S_DONE;
          end else if (sts_i.count_zero) begin
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = ST_NO_SPACE;
            state_d          = S_DONE;
          end else if (sts_i.held_zero) begin
            cmd_o.slot_held = 1'b1;
            state_d         = S_FIT;
          end else begin
            state_d = S_SCAN;
          end
        end else if (sts_i.held_zero) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_NOT_FOUND;
          state_d          = S_DONE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.rd_sel = RD_NEXT;
        if (!sts_i.is_free) begin
          if (sts_i.scan_hit) begin
            cmd_o.slot_idx = 1'b1;
            state_d        = S_FIT;
          end else begin
            cmd_o.scan_step = 1'b1;
            if (sts_i.scan_last) begin
              cmd_o.slot_held = 1'b1;
              state_d         = S_FIT;
            end
          end
        end else if (sts_i.scan_hit) begin
          if (sts_i.scan_last) begin
            cmd_o.dec_held = 1'b1;
            cmd_o.set_res  = 1'b1;
            state_d        = S_DONE;
          end else begin
            cmd_o.del_init = 1'b1;
            state_d        = S_DEL;
          end
        end else if (sts_i.scan_last) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_NOT_FOUND;
          state_d          = S_DONE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_FIT: begin
        if (sts_i.no_fit) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_NO_SPACE;
          state_d          = S_DONE;
        end else if (sts_i.slot_is_held) begin
          cmd_o.ins_write = 1'b1;
          cmd_o.set_res   = 1'b1;
          state_d         = S_DONE;
        end else begin
          cmd_o.fit_prep = 1'b1;
          cmd_o.rd_sel   = RD_TAIL;
          state_d        = S_INS;
        end
      end
      S_INS: begin
        cmd_o.ins_step = 1'b1;
        cmd_o.rd_sel   = RD_PTR_M1;
        if (sts_i.ins_last) begin
          state_d = S_INSW;
        end
      end
      S_INSW: begin
        cmd_o.ins_write = 1'b1;
        cmd_o.set_res   = 1'b1;
        state_d         = S_DONE;
      end
      S_DEL: begin
        cmd_o.del_step = 1'b1;
        cmd_o.rd_sel   = RD_PTR_P2;
        if (sts_i.del_last) begin
          cmd_o.dec_held = 1'b1;
          cmd_o.set_res  = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/ffta_dp.sv]
// Datapath of the tile range allocator: range table, scan cursor and result register.
`timescale 1ns / 1ps
module ffta_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ffta_pkg::TILE_W-1:0]         cfg_wdata_i,
  input  logic                                req_func_i,
  input  logic [ffta_pkg::LEN_W-1:0]          req_count_i,
  input  logic [ffta_pkg::TILE_W-1:0]         req_start_i,
  input  logic                                m_tready_i,
  output logic                                m_tvalid_o,
  output logic [ffta_pkg::TILE_W-1:0]         m_placed_o,
  output logic [ffta_pkg::CNT_W-1:0]          m_count_o,
  output ffta_pkg::status_e                   m_status_o,
  input  ffta_pkg::ffta_cmd_t                 cmd_i,
  output ffta_pkg::ffta_sts_t                 sts_o
);
  import ffta_pkg::*;

  logic [TILE_W-1:0]  base_q;
  logic               func_q;
  logic [LEN_W-1:0]   count_q;
  logic [TILE_W-1:0]  start_q;
  logic [CUR_W-1:0]   cursor_q, cursor_d;
  logic [IDX_W-1:0]   idx_q, ptr_q, slot_q;
  logic [CNT_W-1:0]   held_q;
  logic [TILE_W-1:0]  placed_q;
  status_e            res_q;
  logic               out_valid_q;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic [TILE_W-1:0]  ent_start;
  logic [LEN_W-1:0]   ent_len;
  logic [CUR_W-1:0]   ent_end;
  logic [CUR_W-1:0]   need_end;

  // Each entry holds the length in the upper and the start in the lower bits.
  assign ent_start = ram_rdata[TILE_W-1:0];
  assign ent_len   = ram_rdata[ENTRY_W-1:TILE_W];
  assign ent_end   = CUR_W'(ent_start) + CUR_W'(ent_len);
  assign need_end  = cursor_q + CUR_W'(count_q);
  assign cursor_d  = (ent_end > cursor_q) ? ent_end : cursor_q;

  ffta_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_RANGES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = ram_rdata;
    if (cmd_i.ins_step) begin
      ram_we    = 1'b1;
      ram_waddr = ptr_q + IDX_W'(1);
    end else if (cmd_i.del_step) begin
      ram_we    = 1'b1;
    end else if (cmd_i.ins_write) begin
      ram_we    = 1'b1;
      ram_waddr = slot_q;
      ram_wdata = {count_q, cursor_q[TILE_W-1:0]};
    end
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_ZERO:   ram_raddr = '0;
      RD_NEXT:   ram_raddr = idx_q + IDX_W'(1);
      RD_TAIL:   ram_raddr = IDX_W'(held_q - CNT_W'(1));
      RD_PTR_M1: ram_raddr = ptr_q - IDX_W'(1);
      RD_PTR_P2: ram_raddr = ptr_q + IDX_W'(2);
      default:   ram_raddr = '0;
    endcase
  end

  always_comb begin
    sts_o.is_free      = func_q;
    sts_o.held_zero    = (held_q == '0);
    sts_o.held_full    = (held_q == CNT_W'(MAX_RANGES));
    sts_o.count_zero   = (count_q == '0);
    sts_o.scan_hit     = func_q ? (ent_start == start_q) : (CUR_W'(ent_start) >= need_end);
    sts_o.scan_last    = ((CNT_W'(idx_q) + CNT_W'(1)) == held_q);
    sts_o.no_fit       = (need_end > CUR_W'(TILE_SPACE));
    sts_o.slot_is_held = (CNT_W'(slot_q) == held_q);
    sts_o.ins_last     = (ptr_q == slot_q);
    sts_o.del_last     = ((CNT_W'(ptr_q) + CNT_W'(2)) == held_q);
    sts_o.out_free     = !out_valid_q || m_tready_i;
  end

  // Request, cursor and table pointers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q  <= req_func_i;
      count_q <= req_count_i;
      start_q <= req_start_i;
    end
    if (cmd_i.start) begin
      cursor_q <= CUR_W'(base_q);
      idx_q    <= '0;
      placed_q <= '0;
    end else if (cmd_i.scan_step) begin
      cursor_q <= cursor_d;
      idx_q    <= idx_q + IDX_W'(1);
    end
    if (cmd_i.slot_idx) begin
      slot_q <= idx_q;
    end else if (cmd_i.slot_held) begin
      slot_q <= held_q[IDX_W-1:0];
    end
    if (cmd_i.fit_prep) begin
      ptr_q <= IDX_W'(held_q - CNT_W'(1));
    end else if (cmd_i.ins_step) begin
      ptr_q <= ptr_q - IDX_W'(1);
    end else if (cmd_i.del_init) begin
      ptr_q <= idx_q;
    end else if (cmd_i.del_step) begin
      ptr_q <= ptr_q + IDX_W'(1);
    end
    if (cmd_i.ins_write) begin
      placed_q <= cursor_q[TILE_W-1:0];
    end
    if (cmd_i.set_res) begin
      res_q <= cmd_i.res_status;
    end
    if (cmd_i.load_out) begin
      m_placed_o <= placed_q;
      m_count_o  <= held_q;
      m_status_o <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (cmd_i.ins_write) begin
        held_q <= held_q + CNT_W'(1);
      end else if (cmd_i.dec_held) begin
        held_q <= held_q - CNT_W'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;

endmodule

[rtl/core/first_fit_tile_range_allocator_top.sv]
// Top level of the first-fit tile range allocator.
`timescale 1ns / 1ps
// The allocator hands out runs of consecutive tiles from a space of 2048 tiles and takes them
// back. Each input beat is one request: tuser selects allocate (0) or free (1), tdata carries
// the tile count for an allocate and the start tile for a free. Each request yields exactly one
// output beat with the placed start tile, the number of ranges held afterwards and a status
// (0 ok, 1 table full, 2 no space, 3 start not found). Up to 32 ranges are held in a table that
// is kept sorted by start tile in a single-port-write RAM. An allocate scans the table one entry
// per cycle from the base tile upward and, when it lands in front of an existing range, shifts
// the tail of the table up by one entry per cycle; a free scans for the matching start and
// shifts the tail down the same way. The pace of a request is set by the one read and one write
// port of the table RAM; a result that cannot enter the output register while the previous one
// still waits there adds that wait on top. One request is worked on at a time; the next one is
// accepted while the previous result still waits in the output register. The base tile register
// may only be written while no request is in flight.
module first_fit_tile_range_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Base tile register.
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  // Request beats.
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [23:0] s_tdata_i,   // [11:0] tile_count, [22:12] start_tile, [23] zero
  input  logic        s_tuser_i,   // [0] func
  // Result beats.
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [23:0] m_tdata_o,   // [10:0] placed_start, [16:11] range_count, [23:17] zero
  output logic [1:0]  m_tuser_o    // [1:0] status
);
  import ffta_pkg::*;

  ffta_cmd_t         cmd;
  ffta_sts_t         sts;
  logic [TILE_W-1:0] out_placed;
  logic [CNT_W-1:0]  out_count;
  status_e           out_status;

  ffta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffta_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_func_i  (s_tuser_i),
    .req_count_i (s_tdata_i[11:0]),
    .req_start_i (s_tdata_i[22:12]),
    .m_tready_i  (m_tready_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_placed_o  (out_placed),
    .m_count_o   (out_count),
    .m_status_o  (out_status),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  assign m_tdata_o = {7'd0, out_count, out_placed};
  assign m_tuser_o = out_status;

endmodule

[tb/sv/first_fit_tile_range_allocator_top_test.sv]
// Self-checking testbench for the first-fit tile range allocator top level.
`timescale 1ns / 1ps

import ffta_pkg::*;

typedef enum logic {
  OP_ALLOC = 1'b0,
  OP_FREE  = 1'b1
} tile_op_e;

typedef struct packed {
  logic [TILE_W-1:0] placed_start;
  logic [CNT_W-1:0]  range_count;
  status_e           status;
} tile_outcome_t;

// Keeps its own sorted range table and predicts the outcome of each request.
class tile_range_scoreboard;
  logic [TILE_W-1:0] range_start [MAX_RANGES];
  logic [LEN_W-1:0]  range_length [MAX_RANGES];
  int unsigned       ranges_held = 0;
  logic [TILE_W-1:0] base_tile = '0;
  tile_outcome_t     pending_outcomes [$];
  int unsigned       failures = 0;
  int unsigned       allocs_seen = 0;
  int unsigned       frees_seen = 0;
  int unsigned       status_seen [4] = '{0, 0, 0, 0};

  function void set_base(logic [TILE_W-1:0] value);
    base_tile = value;
  endfunction

  function int unsigned owed_count();
    return pending_outcomes.size();
  endfunction

  // First-fit placement: walk the gaps upward from the base tile.
  function status_e place_run(int unsigned tiles, output logic [TILE_W-1:0] placed);
    int unsigned cursor;
    int unsigned slot;
    int unsigned run_end;
    placed = '0;
    if (ranges_held >= MAX_RANGES) return ST_FULL;
    if (tiles == 0) return ST_NO_SPACE;
    cursor = base_tile;
    slot = ranges_held;
    for (int unsigned i = 0; i < ranges_held; i++) begin
      if (range_start[i] >= cursor && range_start[i] - cursor >= tiles) begin
        slot = i;
        break;
      end
      run_end = range_start[i] + range_length[i];
      // Ranges below the scan position only push it upward, never back.
      if (run_end > cursor) cursor = run_end;
    end
    if (cursor + tiles > TILE_SPACE) return ST_NO_SPACE;
    for (int unsigned i = ranges_held; i > slot; i--) begin
      range_start[i]  = range_start[i-1];
      range_length[i] = range_length[i-1];
    end
    range_start[slot]  = cursor[TILE_W-1:0];
    range_length[slot] = tiles[LEN_W-1:0];
    ranges_held++;
    placed = cursor[TILE_W-1:0];
    return ST_OK;
  endfunction

  // Removes the range whose start matches exactly.
  function status_e release_run(logic [TILE_W-1:0] start);
    for (int unsigned i = 0; i < ranges_held; i++) begin
      if (range_start[i] == start) begin
        for (int unsigned j = i; j + 1 < ranges_held; j++) begin
          range_start[j]  = range_start[j+1];
          range_length[j] = range_length[j+1];
        end
        ranges_held--;
        return ST_OK;
      end
    end
    return ST_NOT_FOUND;
  endfunction

  function void note_request(tile_op_e op, logic [LEN_W-1:0] tiles, logic [TILE_W-1:0] start);
    tile_outcome_t want;
    logic [TILE_W-1:0] placed;
    placed = '0;
    if (op == OP_ALLOC) begin
      allocs_seen++;
      want.status = place_run(tiles, placed);
    end else begin
      frees_seen++;
      want.status = release_run(start);
    end
    want.placed_start = placed;
    want.range_count  = ranges_held[CNT_W-1:0];
    pending_outcomes.push_back(want);
  endfunction

  function void check_result(tile_outcome_t got);
    tile_outcome_t want;
    if (pending_outcomes.size() == 0) begin
      $error("result beat with no request outstanding: placed_start %0d range_count %0d",
             got.placed_start, got.range_count);
      failures++;
      return;
    end
    want = pending_outcomes.pop_front();
    status_seen[got.status]++;
    if (got.placed_start !== want.placed_start) begin
      $error("placed_start mismatch: expected %0d, got %0d", want.placed_start,
             got.placed_start);
      failures++;
    end
    if (got.range_count !== want.range_count) begin
      $error("range_count mismatch: expected %0d, got %0d", want.range_count,
             got.range_count);
      failures++;
    end
    if (got.status !== want.status) begin
      $error("status mismatch: expected %0d, got %0d", want.status, got.status);
      failures++;
    end
  endfunction
endclass

module first_fit_tile_range_allocator_top_test;

  // This covers the longest request with margin.
  localparam int unsigned DRAIN_CYCLES      = 100;
  // Long enough for the block to fill its output register and stall its input.
  localparam int unsigned LONG_STALL_CYCLES = 600;
  localparam int unsigned PHASE_ITEMS       = 350;
  // Requests per fill or drain stretch of the random traffic.
  localparam int unsigned SWING_ITEMS       = 48;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [23:0] s_tdata_i = '0;   // [11:0] tile_count, [22:12] start_tile, [23] zero
  logic        s_tuser_i = 1'b0; // [0] func
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [23:0] m_tdata_o;        // [10:0] placed_start, [16:11] range_count, [23:17] zero
  logic [1:0]  m_tuser_o;        // [1:0] status

  // Percent of cycles in which the sender or the receiver holds back.
  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  // Set once by the stimulus; the receiver then holds off for a long stretch.
  bit          long_stall_due = 1'b0;
  bit          long_stall_done = 1'b0;

  tile_range_scoreboard ledger = new;

  first_fit_tile_range_allocator_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o)
  );

  // 8 ns clock period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // The receiver changes tready at the falling edge. The one long hold-off is
  // counted here, so the sender keeps offering beats while results back up.
  initial begin
    forever begin
      @(negedge clk_i);
      if (long_stall_due && !long_stall_done) begin
        long_stall_done = 1'b1;
        m_tready_i <= 1'b0;
        repeat (LONG_STALL_CYCLES - 1) @(negedge clk_i);
      end else begin
        m_tready_i <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Result beats are taken at the rising edge and checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      ledger.check_result(tile_outcome_t'{m_tdata_o[TILE_W-1:0],
                                          m_tdata_o[TILE_W+CNT_W-1:TILE_W],
                                          status_e'(m_tuser_o)});
    end
  end

  // Offers one request beat, with random idle cycles ahead of it, and returns at the
  // falling edge after the beat was accepted. Called and left at a falling edge.
  task automatic send_request(tile_op_e op, logic [11:0] tiles, logic [10:0] start);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= op;
    s_tdata_i  <= {1'b0, start, tiles};
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    ledger.note_request(op, tiles, start);
    @(negedge clk_i);
  endtask

  // Lowers tvalid and waits until every result has arrived and the block has settled,
  // since the base register must not change under a request in flight.
  task automatic wait_idle();
    s_tvalid_i <= 1'b0;
    while (ledger.owed_count() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_base(logic [10:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    ledger.set_base(value);
  endtask

  // Random request. In a fill stretch most beats allocate, in a drain stretch most free.
  // Frees mostly name a start that is held right now; the rest are unknown starts.
  // Counts are mostly short runs, with some long, zero and oversized ones mixed in.
  function automatic void pick_request(bit fill, output tile_op_e op,
                                       output logic [11:0] tiles, output logic [10:0] start);
    int unsigned roll;
    op    = ($urandom_range(99) < (fill ? 80 : 25)) ? OP_ALLOC : OP_FREE;
    tiles = 12'($urandom_range(4095, 0));
    start = 11'($urandom_range(2047, 0));
    if (op == OP_ALLOC) begin
      roll = $urandom_range(99);
      if (roll < 3) tiles = '0;
      else if (roll < 5) tiles = 12'($urandom_range(4095, 2049));
      else if (roll < 10) tiles = 12'($urandom_range(2048, 65));
      else tiles = 12'($urandom_range(64, 1));
    end else if (ledger.ranges_held != 0 && $urandom_range(99) < 80) begin
      start = ledger.range_start[$urandom_range(ledger.ranges_held - 1, 0)];
    end
  endfunction

  task automatic run_random_phase(int unsigned items);
    tile_op_e    op;
    logic [11:0] tiles;
    logic [10:0] start;
    for (int unsigned n = 0; n < items; n++) begin
      pick_request(((n / SWING_ITEMS) % 2) == 0, op, tiles, start);
      send_request(op, tiles, start);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, base tile 0, no idling.
    send_request(OP_FREE, 12'd0, 11'd5);        // free on an empty table
    send_request(OP_ALLOC, 12'd0, 11'd0);       // zero-length run
    send_request(OP_ALLOC, 12'd4095, 11'd0);    // count far beyond the tile space
    send_request(OP_ALLOC, 12'd2049, 11'd0);    // one tile too many
    send_request(OP_ALLOC, 12'd2048, 11'd0);    // whole space, empty table places at base
    send_request(OP_ALLOC, 12'd1, 11'd0);       // nothing left
    send_request(OP_FREE, 12'd0, 11'd0);        // free the only range
    send_request(OP_ALLOC, 12'd16, 11'd0);
    send_request(OP_ALLOC, 12'd16, 11'd0);
    send_request(OP_ALLOC, 12'd16, 11'd0);
    send_request(OP_FREE, 12'd0, 11'd16);       // middle range
    send_request(OP_FREE, 12'd0, 11'd0);        // head range
    send_request(OP_ALLOC, 12'd8, 11'd0);       // lands in the gap before the first range
    send_request(OP_FREE, 12'd4095, 11'd2047);  // unknown start, all field bits high

    // Base at the top of the space: one tile fits, the next does not.
    write_base(11'd2047);
    send_request(OP_ALLOC, 12'd1, 11'd0);
    send_request(OP_ALLOC, 12'd1, 11'd0);
    send_request(OP_FREE, 12'd0, 11'd2047);

    // Raised base with a range below it that the scan has to step over.
    write_base(11'd20);
    send_request(OP_ALLOC, 12'd4, 11'd0);
    send_request(OP_FREE, 12'd0, 11'd20);
    send_request(OP_FREE, 12'd0, 11'd0);
    send_request(OP_FREE, 12'd0, 11'd32);

    // Random traffic: sender idles little and the receiver a lot.
    write_base(11'd0);
    src_idle_pct  = 23;
    sink_idle_pct = 71;
    run_random_phase(PHASE_ITEMS);

    // Now the other way round, with a raised base.
    write_base(11'($urandom_range(255, 1)));
    src_idle_pct  = 71;
    sink_idle_pct = 23;
    run_random_phase(PHASE_ITEMS);

    // Full rate on both sides, with one long receiver hold-off at the start.
    write_base(11'($urandom_range(1023, 256)));
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    long_stall_due = 1'b1;
    run_random_phase(PHASE_ITEMS);

    wait_idle();
    $display("Covered %0d allocate and %0d free requests over five base tile settings.",
             ledger.allocs_seen, ledger.frees_seen);
    $display("Results by status: ok %0d, table full %0d, no space %0d, not found %0d.",
             ledger.status_seen[ST_OK], ledger.status_seen[ST_FULL],
             ledger.status_seen[ST_NO_SPACE], ledger.status_seen[ST_NOT_FOUND]);
    if (ledger.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hang guard, several times the slowest correct run.
  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding.", ledger.owed_count());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
